// ===== hw/rtl/cbc_pkg.sv =====
// cbc_pkg: result kinds and fixed constants for the cartridge bank controller.
// Depends on nothing; imported by cartridge_bank_controller and tb_top.
`default_nettype none

package cbc_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE_DONE = 3'd0,
        KIND_ROM_ADDR   = 3'd1,
        KIND_RAM_DATA   = 3'd2,
        KIND_OPEN_BUS   = 3'd3,
        KIND_INVALID    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_ROM_BANK_COUNT = 2'd0,
        CFG_HAS_RAM        = 2'd1,
        CFG_RAM_BANK_COUNT = 2'd2
    } t_cfg_index;

    localparam int unsigned C_MAX_ROM_BANKS = 512;
    localparam logic [8:0]  C_ROM_LIMIT     = 9'(C_MAX_ROM_BANKS - 1);
    localparam int unsigned C_RAM_BANK_SIZE = 8192;
    localparam logic [3:0]  C_ENABLE_KEY    = 4'hA;
    localparam logic [7:0]  C_OPEN_BUS      = 8'hFF;
    localparam logic [7:0]  C_RAM_BANK_MAX  = 8'h0F;

endpackage

`default_nettype wire

// ===== hw/rtl/cartridge_bank_controller.sv =====
// cartridge_bank_controller: banked ROM/RAM controller for a game cartridge bus.
// Depends on cbc_pkg. Holds the bank registers and the banked external RAM array.
//
// One bus access is taken per cycle while o_busy is low; its result appears on
// the result ports with o_valid in the next cycle, for exactly one cycle, and
// cannot be held off. RAM reads pass through the single-port RAM's registered
// read port; all other accesses are registered to the same timing. After reset
// the RAM is swept to zero one byte per cycle, all RAM_BANKS * 8192 bytes
// (131072 at the default), with o_busy high; the configuration port accepts
// writes at any time out of reset and is always ready.
`default_nettype none

module cartridge_bank_controller #(
    parameter int unsigned RAM_BANKS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic                 i_mode,
    input  wire logic [15:0]          i_address,
    input  wire logic [7:0]           i_write_data,
    output logic                      o_valid,
    output logic [2:0]                o_kind,
    output logic [22:0]               o_rom_address,
    output logic [7:0]                o_read_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [9:0]           i_cfg_data
);
    import cbc_pkg::*;

    localparam int unsigned DEPTH = RAM_BANKS * C_RAM_BANK_SIZE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(DEPTH - 1);
    localparam logic [3:0] RAM_LIMIT = 4'(RAM_BANKS - 1);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_mem_q;

    logic [9:0] r_rom_bank_count;
    logic       r_has_ram;
    logic [4:0] r_ram_bank_count;

    logic       r_ram_enable,   n_ram_enable;
    logic [7:0] r_rom_bank_low, n_rom_bank_low;
    logic       r_rom_bank_high, n_rom_bank_high;
    logic [8:0] r_rom_bank_sel, n_rom_bank_sel;
    logic [3:0] r_ram_bank_sel, n_ram_bank_sel;

    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    logic        r_valid;
    t_kind       r_kind,       n_kind;
    logic [22:0] r_rom_address, n_rom_address;
    logic [7:0]  r_read_fixed,  n_read_fixed;

    logic          accept;
    logic          ram_ok;
    logic          in_ram_range;
    logic [9:0]    rom_count_m1;
    logic [8:0]    rom_mask;
    logic [4:0]    ram_count_m1;
    logic [3:0]    ram_bank_eff;
    logic [16:0]   ram_index;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    assign accept       = i_start && !r_clr_active;
    assign ram_ok       = r_has_ram && r_ram_enable;
    assign in_ram_range = (i_address[15:13] == 3'b101);
    assign rom_count_m1 = r_rom_bank_count - 10'd1;
    assign rom_mask     = rom_count_m1[8:0] & C_ROM_LIMIT;
    assign ram_count_m1 = r_ram_bank_count - 5'd1;
    assign ram_bank_eff = r_ram_bank_sel & ram_count_m1[3:0] & RAM_LIMIT;
    assign ram_index    = {ram_bank_eff, i_address[12:0]};

    always_comb begin
        n_ram_enable    = r_ram_enable;
        n_rom_bank_low  = r_rom_bank_low;
        n_rom_bank_high = r_rom_bank_high;
        n_rom_bank_sel  = r_rom_bank_sel;
        n_ram_bank_sel  = r_ram_bank_sel;
        n_kind          = KIND_WRITE_DONE;
        n_rom_address   = '0;
        n_read_fixed    = '0;
        if (i_mode) begin
            if (i_address[15:13] == 3'b000) begin
                n_ram_enable = (i_write_data[3:0] == C_ENABLE_KEY);
            end else if (i_address[15:12] == 4'h2) begin
                n_rom_bank_low = i_write_data;
                n_rom_bank_sel = {r_rom_bank_high, i_write_data} & rom_mask;
            end else if (i_address[15:12] == 4'h3) begin
                n_rom_bank_high = i_write_data[0];
                n_rom_bank_sel  = {i_write_data[0], r_rom_bank_low} & rom_mask;
            end else if (i_address[15:13] == 3'b010) begin
                if (i_write_data <= C_RAM_BANK_MAX) begin
                    n_ram_bank_sel = i_write_data[3:0];
                end
            end
        end else begin
            if (i_address[15:14] == 2'b00) begin
                n_kind        = KIND_ROM_ADDR;
                n_rom_address = {7'd0, i_address};
            end else if (i_address[15:14] == 2'b01) begin
                n_kind        = KIND_ROM_ADDR;
                n_rom_address = {r_rom_bank_sel, i_address[13:0]};
            end else if (in_ram_range) begin
                if (ram_ok) begin
                    n_kind = KIND_RAM_DATA;
                end else begin
                    n_kind       = KIND_OPEN_BUS;
                    n_read_fixed = C_OPEN_BUS;
                end
            end else begin
                n_kind = KIND_INVALID;
            end
        end
    end

    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = accept && i_mode && in_ram_range && ram_ok;
            mem_addr  = ram_index[AW-1:0];
            mem_wdata = i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ENTRY) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank_count <= 10'd512;
            r_has_ram        <= 1'b1;
            r_ram_bank_count <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROM_BANK_COUNT: r_rom_bank_count <= i_cfg_data;
                CFG_HAS_RAM:        r_has_ram        <= i_cfg_data[0];
                CFG_RAM_BANK_COUNT: r_ram_bank_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enable    <= 1'b0;
            r_rom_bank_low  <= 8'd1;
            r_rom_bank_high <= 1'b0;
            r_rom_bank_sel  <= 9'd1;
            r_ram_bank_sel  <= 4'd0;
            r_valid         <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_ram_enable    <= n_ram_enable;
                r_rom_bank_low  <= n_rom_bank_low;
                r_rom_bank_high <= n_rom_bank_high;
                r_rom_bank_sel  <= n_rom_bank_sel;
                r_ram_bank_sel  <= n_ram_bank_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind        <= n_kind;
            r_rom_address <= n_rom_address;
            r_read_fixed  <= n_read_fixed;
        end
    end

    assign o_busy        = r_clr_active;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_rom_address = r_rom_address;
    assign o_read_data   = (r_kind == KIND_RAM_DATA) ? r_mem_q : r_read_fixed;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for cartridge_bank_controller.
// Depends on cbc_pkg and the controller RTL. Bus accesses are scored against an
// in-bench model of the bank registers and the banked RAM.
`timescale 1ns / 100ps

module tb_top;

    import cbc_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [22:0] rom_address;
        logic [7:0]  read_data;
    } t_bus_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_mode;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [22:0] o_rom_address;
    logic [7:0]  o_read_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    // Model of the cartridge state
    logic [9:0]  rom_banks     = 10'd512;
    logic        ram_present   = 1'b1;
    logic [4:0]  ram_banks     = 5'd16;
    logic        ram_on        = 1'b0;
    logic [7:0]  bank_lo       = 8'd1;
    logic        bank_hi       = 1'b0;
    logic [8:0]  rom_sel       = 9'd1;
    logic [3:0]  ram_sel       = 4'd0;
    bit   [7:0]  ram_bytes [0:131071];

    t_bus_result pending_results [$];
    int unsigned mismatches    = 0;
    int unsigned transactions  = 0;
    int unsigned settings_used = 0;
    int unsigned kind_seen [5] = '{default: 0};
    bit          steady        = 1'b0;

    cartridge_bank_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_rom_address (o_rom_address),
        .o_read_data   (o_read_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    function automatic t_bus_result predict_access(input logic mode, input logic [15:0] addr,
                                                   input logic [7:0] data);
        t_bus_result r;
        logic [9:0]  rom_span;
        logic [4:0]  ram_span;
        logic [16:0] ram_addr;
        logic        ram_live;
        r        = '{KIND_WRITE_DONE, 23'd0, 8'd0};
        rom_span = rom_banks - 10'd1;
        ram_span = ram_banks - 5'd1;
        ram_addr = {ram_sel & ram_span[3:0], addr[12:0]};
        ram_live = ram_present && ram_on;
        if (mode) begin
            if (addr < 16'h2000) begin
                ram_on = (data[3:0] == C_ENABLE_KEY);
            end else if (addr < 16'h3000) begin
                bank_lo = data;
                rom_sel = {bank_hi, bank_lo} & rom_span[8:0];
            end else if (addr < 16'h4000) begin
                bank_hi = data[0];
                rom_sel = {bank_hi, bank_lo} & rom_span[8:0];
            end else if (addr < 16'h6000) begin
                if (data <= C_RAM_BANK_MAX)
                    ram_sel = data[3:0];
            end else if (addr >= 16'hA000 && addr < 16'hC000) begin
                if (ram_live)
                    ram_bytes[ram_addr] = data;
            end
        end else begin
            if (addr < 16'h4000) begin
                r.kind        = KIND_ROM_ADDR;
                r.rom_address = {7'd0, addr};
            end else if (addr < 16'h8000) begin
                r.kind        = KIND_ROM_ADDR;
                r.rom_address = {rom_sel, addr[13:0]};
            end else if (addr >= 16'hA000 && addr < 16'hC000) begin
                if (ram_live) begin
                    r.kind      = KIND_RAM_DATA;
                    r.read_data = ram_bytes[ram_addr];
                end else begin
                    r.kind      = KIND_OPEN_BUS;
                    r.read_data = C_OPEN_BUS;
                end
            end else begin
                r.kind = KIND_INVALID;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_bus_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction", 32'(o_kind), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_kind < 3'd5)
                    kind_seen[o_kind]++;
                if (o_kind !== want.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(want.kind));
                if (o_rom_address !== want.rom_address)
                    report_mismatch("rom_address", 32'(o_rom_address),
                                    32'(want.rom_address));
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", 32'(o_read_data), 32'(want.read_data));
            end
        end
    end

    // Call at a falling edge; returns at a falling edge with start still held.
    task automatic send_access(input logic mode, input logic [15:0] addr, input logic [7:0] data);
        while (!steady && $urandom_range(0, 99) < 36) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start      <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_access(mode, addr, data));
        transactions++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [9:0] rom_count, input logic present,
                                 input logic [4:0] ram_count);
        logic [9:0] vals [3];
        vals = '{rom_count, {9'd0, present}, {5'd0, ram_count}};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_index'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_index'(i))
                CFG_ROM_BANK_COUNT: rom_banks   = vals[i];
                CFG_HAS_RAM:        ram_present = vals[i][0];
                CFG_RAM_BANK_COUNT: ram_banks   = vals[i][4:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] ram_window();
        if ($urandom_range(0, 1))
            return 16'hA000 + 16'($urandom_range(0, 15));
        return 16'($urandom_range(16'hA000, 16'hBFFF));
    endfunction

    task automatic test_reset_view();
        send_access(1'b0, 16'h0000, 8'h00);
        send_access(1'b0, 16'h4000, 8'hFF);
        send_access(1'b0, 16'h7FFF, 8'h00);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b0, 16'h8000, 8'h00);
        send_access(1'b0, 16'hC000, 8'h00);
        send_access(1'b0, 16'hFFFF, 8'h00);
    endtask

    task automatic test_ram_enable();
        send_access(1'b1, 16'h1FFF, 8'h3A);
        send_access(1'b1, 16'hBFFF, 8'hFF);
        send_access(1'b0, 16'hBFFF, 8'h00);
        send_access(1'b1, 16'h0000, 8'hA5);
        send_access(1'b1, 16'hA000, 8'h55);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b1, 16'h0000, 8'h0A);
    endtask

    task automatic test_rom_banking();
        send_access(1'b1, 16'h2000, 8'hFF);
        send_access(1'b1, 16'h3000, 8'h01);
        send_access(1'b0, 16'h7FFF, 8'h00);
        send_access(1'b1, 16'h2FFF, 8'h00);
        send_access(1'b1, 16'h3FFF, 8'hFE);
        send_access(1'b0, 16'h4000, 8'h00);
    endtask

    task automatic test_ram_banking();
        send_access(1'b1, 16'h4000, 8'h0F);
        send_access(1'b1, 16'hA000, 8'h77);
        send_access(1'b1, 16'h5FFF, 8'h10);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b1, 16'h4000, 8'h00);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b1, 16'h6000, 8'h12);
    endtask

    task automatic test_random_traffic(input int count);
        logic        m;
        logic [15:0] a;
        logic [7:0]  d;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                wait_drained();
            m = 1'b1;
            a = 16'($urandom);
            d = 8'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    a = 16'($urandom_range(16'h0000, 16'h1FFF));
                    if ($urandom_range(0, 9) < 6)
                        d[3:0] = C_ENABLE_KEY;
                end
                1: a = 16'($urandom_range(16'h2000, 16'h2FFF));
                2: a = 16'($urandom_range(16'h3000, 16'h3FFF));
                3: begin
                    a = 16'($urandom_range(16'h4000, 16'h5FFF));
                    if ($urandom_range(0, 3) != 0)
                        d = 8'($urandom_range(0, 15));
                end
                4, 5: a = ram_window();
                6, 7: begin
                    m = 1'b0;
                    a = ram_window();
                end
                8: begin
                    m = 1'b0;
                    a = 16'($urandom_range(16'h0000, 16'h7FFF));
                end
                default: m = 1'($urandom_range(0, 1));
            endcase
            send_access(m, a, d);
        end
    endtask

    task automatic test_register_settings();
        wait_drained();
        load_settings(10'd2, 1'b1, 5'd1);
        test_random_traffic(66);
        wait_drained();
        load_settings(10'd64, 1'b0, 5'd4);
        test_random_traffic(66);
        wait_drained();
        load_settings(10'd8, 1'b1, 5'd2);
        steady = 1'b1;
        test_random_traffic(66);
        steady = 1'b0;
        wait_drained();
        load_settings(10'd256, 1'b1, 5'd8);
        test_random_traffic(66);
        wait_drained();
        load_settings(10'd512, 1'b1, 5'd16);
        test_random_traffic(70);
        wait_drained();
        load_settings(10'd32, 1'b1, 5'd16);
        test_random_traffic(66);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_mode       = 1'b0;
        i_address    = 16'd0;
        i_write_data = 8'd0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_ROM_BANK_COUNT;
        i_cfg_data   = 10'd0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_view();
        test_ram_enable();
        test_rom_banking();
        test_ram_banking();
        test_register_settings();

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d bus transactions over %0d register settings after reset.",
                 transactions, settings_used);
        $display("Results by kind: write %0d, rom %0d, ram %0d, open bus %0d, invalid %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cbc_pkg.sv
hw/rtl/cartridge_bank_controller.sv
tb/tb_top.sv
